### rtl/core/gae_pkg.sv
// ----------------------------------------------------------------------------
// gae_pkg: shared types and helpers for the 4bpp glyph alpha expander
// Holds the register index codes, the blend request record and the
// nibble scaling function used by the expansion stage.
// ----------------------------------------------------------------------------
package gae_pkg;

  localparam int unsigned MAX_GLYPH_DIM_DEF = 255;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned DIM_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_START_ODD   = 3'd4,
    REG_OPACITY     = 3'd5,
    REG_INK_COLOR   = 3'd6
  } cfg_idx_t;

  // One blend request as it leaves the block.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic [ALPHA_W-1:0]        alpha;
    logic                      last;
  } pix_t;

  // Results of one glyph byte, handed from the expansion stage to the buffer.
  typedef struct packed {
    logic [1:0] cnt;
    pix_t       p0;
    pix_t       p1;
  } pix_pair_t;

  // Widen a nibble to 8 bits (n * 0x11) and scale by brush / 255, truncated.
  // The division by 255 uses the exact identity floor(x / 255) =
  // (x + (x >> 8) + 1) >> 8 for any x up to 255 * 255, the largest product.
  function automatic logic [ALPHA_W-1:0] scale_nibble(input logic [3:0] nib,
                                                      input logic [7:0] brush);
    logic [15:0] prod;
    logic [16:0] acc;
    prod = {nib, nib} * brush;
    acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

endpackage

### rtl/core/glyph_4bpp_alpha_expand.sv
// ----------------------------------------------------------------------------
// glyph_4bpp_alpha_expand: 4bpp anti-aliased glyph to blend request expander
// Turns packed coverage bytes into screen-positioned, brush-scaled blend
// requests for the pixels of a clipped glyph area.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       sink       in_valid / in_stall    in_glyph_byte
//   out_      source     out_valid / out_stall  out_pixel_x/y/color/alpha, out_last
//   cfg_      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A glyph byte is held in the input register and expanded in one pass into
// a two-entry result register; requests leave it one per cycle while out_stall
// is low. The next byte loads once the register is empty or as its last request
// leaves, so the single result port limits the byte rate. A byte passes the
// input register and then the result register before its first request.
// Reset (rst_n low, synchronous) empties both registers, clears the row and
// column counters and loads the register reset values. A stall on the
// result side holds the buffered requests and, once the buffer cannot take
// the next byte, stalls the input. Configuration is always ready.
// ----------------------------------------------------------------------------
module glyph_4bpp_alpha_expand import gae_pkg::*; #(
  parameter int unsigned MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         in_glyph_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_pixel_x,
  output logic signed [COORD_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic [ALPHA_W-1:0]        out_pixel_alpha,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // Registers. Users must change them only while the block is idle; not enforced.
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [DIM_W-1:0]          area_width_r;
  logic [DIM_W-1:0]          area_height_r;
  logic                      start_odd_r;
  logic [ALPHA_W-1:0]        opacity_r;
  logic [COLOR_W-1:0]        ink_color_r;

  logic      load, load_ok;
  pix_pair_t pair;
  pix_t      head;

  assign cfg_ready = 1'b1;

  // Writes to indexes past the register list are accepted and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      area_width_r  <= DIM_W'(1);
      area_height_r <= DIM_W'(1);
      start_odd_r   <= 1'b0;
      opacity_r     <= '1;
      ink_color_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x_r    <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_data[COORD_W-1:0];
        REG_AREA_WIDTH:  area_width_r  <= cfg_data[DIM_W-1:0];
        REG_AREA_HEIGHT: area_height_r <= cfg_data[DIM_W-1:0];
        REG_START_ODD:   start_odd_r   <= cfg_data[0];
        REG_OPACITY:     opacity_r     <= cfg_data[ALPHA_W-1:0];
        REG_INK_COLOR:   ink_color_r   <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Expansion stage: byte register, counters and nibble scaling.
  gae_expand #(
    .MAX_GLYPH_DIM(MAX_GLYPH_DIM)
  ) u_expand (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_glyph_byte(in_glyph_byte),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .area_width   (area_width_r),
    .area_height  (area_height_r),
    .start_odd    (start_odd_r),
    .opacity      (opacity_r),
    .ink_color    (ink_color_r),
    .load_ok      (load_ok),
    .load         (load),
    .pair         (pair)
  );

  // Result register: serializes the one or two requests of a byte.
  gae_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .pair     (pair),
    .load_ok  (load_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign out_pixel_x     = head.x;
  assign out_pixel_y     = head.y;
  assign out_pixel_color = head.color;
  assign out_pixel_alpha = head.alpha;
  assign out_last        = head.last;

endmodule

### rtl/core/gae_expand.sv
// ----------------------------------------------------------------------------
// gae_expand: input register and pixel expansion stage
// Holds the accepted glyph byte and the row and column counters, and turns
// the byte into zero, one or two blend requests in a single pass.
// ----------------------------------------------------------------------------
module gae_expand import gae_pkg::*; #(
  parameter int unsigned MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         in_glyph_byte,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic [DIM_W-1:0]          area_width,
  input  logic [DIM_W-1:0]          area_height,
  input  logic                      start_odd,
  input  logic [ALPHA_W-1:0]        opacity,
  input  logic [COLOR_W-1:0]        ink_color,
  input  logic                      load_ok,
  output logic                      load,
  output pix_pair_t                 pair
);

  localparam int unsigned CNT_W = $clog2(MAX_GLYPH_DIM + 1);
  localparam int unsigned EXT_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;

  logic              byte_valid_r, byte_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;

  logic [CNT_W-1:0] w, h;
  logic [CNT_W-1:0] row0, row1, col1, col_end, row_inc;
  logic             single, second, draw, emit0, emit1, take_in;
  logic [ALPHA_W-1:0] a0, a1;
  pix_t             p0, p1;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (v == '0) return CNT_W'(1);
    if (ve > EXT_W'(MAX_GLYPH_DIM)) return CNT_W'(MAX_GLYPH_DIM);
    return CNT_W'(ve);
  endfunction

  assign w = clamp_dim(area_width);
  assign h = clamp_dim(area_height);

  assign load     = byte_valid_r && load_ok;
  assign take_in  = !byte_valid_r || load;
  assign in_stall = !take_in;

  always_comb begin
    // Counters left beyond a shrunk area wrap before the byte is used.
    row0 = (row_r >= h) ? '0 : row_r;
    if (col_r >= w) begin
      col1 = '0;
      row1 = (row0 + CNT_W'(1) >= h) ? '0 : row0 + CNT_W'(1);
    end else begin
      col1 = col_r;
      row1 = row0;
    end
    single = start_odd && (col1 == '0);
    second = !single && (col1 + CNT_W'(1) < w);
    draw   = (opacity != '0);
    a0     = scale_nibble(single ? byte_r[3:0] : byte_r[7:4], opacity);
    a1     = scale_nibble(byte_r[3:0], opacity);
    emit0  = draw && (a0 != '0);
    emit1  = draw && second && (a1 != '0);

    col_end = second ? col1 + CNT_W'(2) : col1 + CNT_W'(1);
    row_inc = (row1 + CNT_W'(1) >= h) ? '0 : row1 + CNT_W'(1);

    p0.x     = origin_x + COORD_W'(col1);
    p0.y     = origin_y + COORD_W'(row1);
    p0.color = ink_color;
    p0.alpha = a0;
    p0.last  = !emit1;
    p1.x     = origin_x + COORD_W'(col1 + CNT_W'(1));
    p1.y     = p0.y;
    p1.color = ink_color;
    p1.alpha = a1;
    p1.last  = 1'b1;

    pair.cnt = 2'({1'b0, emit0} + {1'b0, emit1});
    pair.p0  = emit0 ? p0 : p1;
    pair.p1  = p1;

    col_nxt = col_r;
    row_nxt = row_r;
    if (load) begin
      if (col_end >= w) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_end;
        row_nxt = row1;
      end
    end
    byte_valid_nxt = take_in ? in_valid : byte_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in && in_valid) begin
      byte_r <= in_glyph_byte;
    end
  end

endmodule

### rtl/core/gae_outbuf.sv
// ----------------------------------------------------------------------------
// gae_outbuf: two-entry result register
// Takes one byte's requests at once, presents one per cycle while unstalled.
// ----------------------------------------------------------------------------
module gae_outbuf import gae_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  pix_pair_t pair,
  output logic      load_ok,
  output logic      out_valid,
  input  logic      out_stall,
  output pix_t      head
);

  logic [1:0] cnt_r, cnt_nxt;
  pix_t       slot0_r, slot0_nxt;
  pix_t       slot1_r, slot1_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign head      = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = pair.cnt;
      slot0_nxt = pair.p0;
      slot1_nxt = pair.p1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### rtl/core/gae_checker.sv
// ----------------------------------------------------------------------------
// gae_checker: port-level assertions for the glyph alpha expander
// Watches the top-level ports and is attached by the bind at the end.
// ----------------------------------------------------------------------------
module gae_checker import gae_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_pixel_x,
  input logic signed [COORD_W-1:0] out_pixel_y,
  input logic [COLOR_W-1:0]        out_pixel_color,
  input logic [ALPHA_W-1:0]        out_pixel_alpha,
  input logic                      out_last
);

  // A stalled request stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_pixel_color) &&
      $stable(out_pixel_alpha) && $stable(out_last))
    else $error("stalled result changed");

  // Requests with zero weight are never sent.
  a_alpha_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_alpha != '0)
    else $error("result with zero alpha");

  // The second request of a byte is already buffered behind the first.
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("second request of a byte missing");

  // Reset leaves nothing on the result port.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind glyph_4bpp_alpha_expand gae_checker u_gae_checker (.*);

### dv/glyph_4bpp_alpha_expand_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_4bpp_alpha_expand_checker: blend request predictor and comparator
// Follows every register write and glyph byte transfer, works out the blend
// requests each byte must cause, and compares the requests leaving the block
// against them in order, field by field.
// ----------------------------------------------------------------------------
module glyph_4bpp_alpha_expand_checker import gae_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [BYTE_W-1:0]         in_glyph_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_pixel_x,
  input  logic signed [COORD_W-1:0] out_pixel_y,
  input  logic [COLOR_W-1:0]        out_pixel_color,
  input  logic [ALPHA_W-1:0]        out_pixel_alpha,
  input  logic                      out_last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int unsigned               mismatch_count,
  output int unsigned               blends_pending
);

  // Shadow of the area registers.
  logic [COORD_W-1:0] left_x;
  logic [COORD_W-1:0] top_y;
  logic [DIM_W-1:0]   span_w;
  logic [DIM_W-1:0]   span_h;
  logic               odd_first;
  logic [ALPHA_W-1:0] brush;
  logic [COLOR_W-1:0] ink;

  // Position of the next pixel inside the glyph area.
  int unsigned cur_col;
  int unsigned cur_row;

  pix_t        blend_due_q[$];
  int unsigned errs;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t blend mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errs++;
  endtask

  function automatic int unsigned area_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_GLYPH_DIM_DEF) return MAX_GLYPH_DIM_DEF;
    return v;
  endfunction

  // Nibble widened to 8 bits, then scaled by brush / 255 with truncation.
  function automatic logic [ALPHA_W-1:0] coverage_alpha(input logic [3:0] nib);
    int unsigned wide;
    wide = nib * 17;
    return ALPHA_W'((wide * brush) / 255);
  endfunction

  task automatic advance_row(input int unsigned rows);
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows) cur_row = 0;
  endtask

  task automatic queue_blend(input int unsigned col, input logic [ALPHA_W-1:0] a);
    pix_t p;
    if (a == 0) return;
    p.x     = left_x + col[COORD_W-1:0];
    p.y     = top_y + cur_row[COORD_W-1:0];
    p.color = ink;
    p.alpha = a;
    p.last  = 1'b0;
    blend_due_q.push_back(p);
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned before_n;
    bit          paint;
    pix_t        tail;
    w = area_dim(span_w);
    h = area_dim(span_h);
    before_n = blend_due_q.size();
    paint = (brush != 0);
    // Counters may sit outside an area that was shrunk between glyphs.
    if (cur_row >= h) cur_row = 0;
    if (cur_col >= w) advance_row(h);
    col = cur_col;
    if (odd_first && col == 0) begin
      if (paint) queue_blend(col, coverage_alpha(b[3:0]));
      col++;
    end else begin
      if (paint) queue_blend(col, coverage_alpha(b[7:4]));
      col++;
      if (col < w) begin
        if (paint) queue_blend(col, coverage_alpha(b[3:0]));
        col++;
      end
    end
    if (col >= w) advance_row(h);
    else cur_col = col;
    if (blend_due_q.size() > before_n) begin
      tail = blend_due_q.pop_back();
      tail.last = 1'b1;
      blend_due_q.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    pix_t want;
    if (!rst_n) begin
      left_x    = '0;
      top_y     = '0;
      span_w    = 8'd1;
      span_h    = 8'd1;
      odd_first = 1'b0;
      brush     = 8'd255;
      ink       = '0;
      cur_col   = 0;
      cur_row   = 0;
      blend_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_ORIGIN_X:    left_x    = cfg_data[COORD_W-1:0];
          REG_ORIGIN_Y:    top_y     = cfg_data[COORD_W-1:0];
          REG_AREA_WIDTH:  span_w    = cfg_data[DIM_W-1:0];
          REG_AREA_HEIGHT: span_h    = cfg_data[DIM_W-1:0];
          REG_START_ODD:   odd_first = cfg_data[0];
          REG_OPACITY:     brush     = cfg_data[ALPHA_W-1:0];
          REG_INK_COLOR:   ink       = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (blend_due_q.size() == 0) begin
          note_mismatch("request with none due, alpha", out_pixel_alpha, '0);
        end else begin
          want = blend_due_q.pop_front();
          if (out_pixel_x !== want.x) note_mismatch("pixel_x", out_pixel_x, want.x);
          if (out_pixel_y !== want.y) note_mismatch("pixel_y", out_pixel_y, want.y);
          if (out_pixel_color !== want.color)
            note_mismatch("pixel_color", out_pixel_color, want.color);
          if (out_pixel_alpha !== want.alpha)
            note_mismatch("pixel_alpha", out_pixel_alpha, want.alpha);
          if (out_last !== want.last) note_mismatch("last", out_last, want.last);
        end
      end
      if (in_valid && !in_stall) predict_byte(in_glyph_byte);
    end
    mismatch_count <= errs;
    blends_pending <= blend_due_q.size();
  end

endmodule

### dv/glyph_4bpp_alpha_expand_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_4bpp_alpha_expand_tb: stimulus and verdict for the glyph expander
// Programs glyph areas through the register port, streams coverage bytes
// into the block and lets the checker predict and compare every blend
// request. A directed opening covers the corner cases, then four random
// phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module glyph_4bpp_alpha_expand_tb import gae_pkg::*; ();

  // Cycles with no transfer on any channel before the run is declared hung.
  // The worst honest gap is a long random stall at 85 percent, far below this.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Cycles to wait after the last expected request, so that a trailing byte
  // that produces nothing has left the pipeline before registers change.
  localparam int unsigned SETTLE_CYCLES = 10;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [BYTE_W-1:0]         in_glyph_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_pixel_x;
  logic signed [COORD_W-1:0] out_pixel_y;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic [ALPHA_W-1:0]        out_pixel_alpha;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int unsigned mismatch_count;
  int unsigned blends_pending;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  glyph_4bpp_alpha_expand dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_byte   (in_glyph_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_alpha (out_pixel_alpha),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  glyph_4bpp_alpha_expand_checker blend_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_byte   (in_glyph_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_alpha (out_pixel_alpha),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .blends_pending  (blends_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver decides afresh on every edge whether to hold off the next
  // request. With stall_pct at zero it simply takes everything.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hang detector: any transfer on any of the three channels resets it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one register write and holds it until the block takes it. The
  // valid stays high afterwards so that back-to-back writes need no gap; the
  // caller drops it after the last write.
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Offers one glyph byte, after a random number of idle cycles when the
  // current phase asks for sender gaps. The byte stays put until the
  // transfer happens, and valid is left high for a possible next byte.
  task automatic feed_glyph_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_glyph_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every predicted request has come out,
  // then a few more cycles for any byte that produces no request at all.
  task automatic wait_blends_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blends_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the full register set. Bits above each register's width carry
  // random junk, which the block has to ignore.
  task automatic load_area(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic odd, input logic [ALPHA_W-1:0] br,
                           input logic [COLOR_W-1:0] color);
    write_register(REG_ORIGIN_X,    {16'($urandom()), ox});
    write_register(REG_ORIGIN_Y,    {16'($urandom()), oy});
    write_register(REG_AREA_WIDTH,  {24'($urandom()), w});
    write_register(REG_AREA_HEIGHT, {24'($urandom()), h});
    write_register(REG_START_ODD,   {31'($urandom()), odd});
    write_register(REG_OPACITY,     {24'($urandom()), br});
    write_register(REG_INK_COLOR,   color);
    cfg_valid <= 1'b0;
  endtask

  // A random area. Origins often sit just below the signed limit (x) or 0 (y)
  // so that coordinates wrap; sizes are mostly small so rows turn over often,
  // with the zero and full-size values mixed in. Brush alpha hits its extremes.
  task automatic load_random_area();
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [ALPHA_W-1:0] br;
    int unsigned        pick;
    ox = ($urandom_range(3) == 0) ? 16'h7ff8 + 16'($urandom_range(15)) : 16'($urandom());
    oy = ($urandom_range(3) == 0) ? 16'hfff8 + 16'($urandom_range(15)) : 16'($urandom());
    pick = $urandom_range(19);
    w = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'($urandom())
                                                                : 8'($urandom_range(1, 9));
    pick = $urandom_range(19);
    h = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'($urandom())
                                                                : 8'($urandom_range(1, 6));
    pick = $urandom_range(9);
    br = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 : 8'($urandom());
    load_area(ox, oy, w, h, 1'($urandom()), br, $urandom());
  endtask

  initial begin
    int unsigned    phase;
    int unsigned    area_n;
    int unsigned    byte_n;
    int unsigned    pick;
    logic [BYTE_W-1:0] b;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_glyph_byte = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ORIGIN_X;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a one-pixel area, so only the high nibble counts.
    feed_glyph_byte(8'hf0);
    feed_glyph_byte(8'h0f);
    feed_glyph_byte(8'h80);
    wait_blends_done();

    // Rows starting on an odd pixel with an odd remainder, x running past
    // the signed limit and y wrapping from -1 to 0 on the second row.
    load_area(16'h7ffe, 16'hffff, 8'd5, 8'd2, 1'b1, 8'd255, 32'ha5a5_5a5a);
    feed_glyph_byte(8'h0f);
    feed_glyph_byte(8'h12);
    feed_glyph_byte(8'hf8);
    feed_glyph_byte(8'he1);
    feed_glyph_byte(8'h00);
    feed_glyph_byte(8'h7f);
    wait_blends_done();

    // Zero brush alpha and zero-sized area: bytes are consumed silently.
    load_area(16'h8000, 16'h7fff, 8'd0, 8'd0, 1'b0, 8'd0, 32'hffff_ffff);
    feed_glyph_byte(8'hff);
    feed_glyph_byte(8'h55);
    wait_blends_done();

    // The faintest brush: full coverage scales to 1, coverage 1 to nothing.
    write_register(REG_OPACITY, 32'd1);
    cfg_valid <= 1'b0;
    feed_glyph_byte(8'hff);
    feed_glyph_byte(8'h10);
    wait_blends_done();

    // Full-size area, left mid-row; then the width and height shrink below
    // the counters, which must wrap before the next byte is placed.
    load_area(16'h0000, 16'h0000, 8'd255, 8'd255, 1'b1, 8'd128, 32'h0123_4567);
    feed_glyph_byte(8'h3c);
    feed_glyph_byte(8'hff);
    feed_glyph_byte(8'h11);
    feed_glyph_byte(8'h9a);
    wait_blends_done();
    write_register(REG_AREA_WIDTH, 32'd3);
    cfg_valid <= 1'b0;
    feed_glyph_byte(8'hc3);
    feed_glyph_byte(8'h77);
    wait_blends_done();
    write_register(REG_AREA_HEIGHT, 32'd1);
    write_register(REG_START_ODD, 32'd0);
    cfg_valid <= 1'b0;
    feed_glyph_byte(8'he0);
    wait_blends_done();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    // Each phase runs through several areas; counters are carried across
    // area changes, so partial glyphs land in the next area on purpose.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (area_n = 0; area_n < 4; area_n++) begin
        load_random_area();
        byte_n = $urandom_range(30, 50);
        repeat (byte_n) begin
          pick = $urandom_range(7);
          b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom());
          feed_glyph_byte(b);
        end
        wait_blends_done();
      end
    end

    if (mismatch_count == 0 && blends_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
